/* rtl/core/itwp_pkg.sv */
// Shared types and constants for the interval timer with pause.
// Operation codes, item classes, queue sizing, the queued item and the register set.
// No dependencies.
package itwp_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int NOW_W          = 64;
  localparam int AGE_W          = 64;
  localparam int INTERVAL_W     = 32;
  localparam int OP_W           = 3;

  localparam int QUEUE_DEPTH = 2;

  // Operation codes as they arrive on the input channel.
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd0;
  localparam logic [OP_W-1:0] OP_START  = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

  // Item classes handed from the front end to the back end.
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_UPDATE = 3'd1;
  localparam logic [CLS_W-1:0] CLS_START  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_STOP   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_PAUSE  = 3'd4;
  localparam logic [CLS_W-1:0] CLS_RESUME = 3'd5;

  // Register indexes on the configuration port.
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_USE_TICKS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAUSABLE    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SINGLE_SHOT = 2'd3;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [NOW_W-1:0] now;
    logic             paused;
    logic             tick;
  } item_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic                  use_ticks;
    logic                  pausable;
    logic                  single_shot;
  } cfg_t;

endpackage

/* rtl/core/interval_timer_with_pause.sv */
// Top level of the interval timer with pause: configuration registers and the
// front end, queue and back end. Depends on itwp_pkg, itwp_front, itwp_queue, itwp_back.
//
// One interval timer driven by operation beats (update, start, stop, pause,
// resume); every accepted beat yields exactly one result beat with fired,
// running and elapsed. For start, stop, pause, resume, an ignored code or an
// update while stopped or frozen the back end goes from S_IDLE straight to S_OUT;
// any other update passes through S_CMP, and a periodic update that fires with
// a nonzero interval (single_shot clear) then passes through S_DIV, where the
// remainder of the 64-bit age by the 32-bit interval is found one
// bit per cycle in the back end. A two-entry queue lets the input side take up
// to two beats ahead of the back end while a result waits at the output. Only
// the low TIME_WIDTH bits of now are used, and time differences wrap at that width.
// Registers at byte addresses 0 interval, 4 use_ticks, 8 pausable,
// 12 single_shot; write them only while no item is in flight.
module interval_timer_with_pause #(
  parameter int TIME_WIDTH = itwp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itwp_pkg::OP_W-1:0]     operation,
  input  logic [itwp_pkg::NOW_W-1:0]    now,
  input  logic                          paused,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          fired,
  output logic                          running,
  output logic [itwp_pkg::AGE_W-1:0]    elapsed
);
  import itwp_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_INTERVAL:    cfg.interval    <= pwdata;
        REG_USE_TICKS:   cfg.use_ticks   <= pwdata[0];
        REG_PAUSABLE:    cfg.pausable    <= pwdata[0];
        REG_SINGLE_SHOT: cfg.single_shot <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INTERVAL:    prdata = cfg.interval;
      REG_USE_TICKS:   prdata = 32'(cfg.use_ticks);
      REG_PAUSABLE:    prdata = 32'(cfg.pausable);
      REG_SINGLE_SHOT: prdata = 32'(cfg.single_shot);
      default:         prdata = '0;
    endcase
  end

  itwp_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .now       (now),
    .paused    (paused),
    .tick      (tick),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  itwp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  itwp_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .fired     (fired),
    .running   (running),
    .elapsed   (elapsed)
  );

endmodule

/* rtl/core/itwp_front.sv */
// Front end: takes input beats, decodes the operation and trims the time stamp.
// Pushes one classified item per accepted beat into the queue. Uses itwp_pkg.
module itwp_front #(
  parameter int TIME_WIDTH = itwp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [itwp_pkg::OP_W-1:0]     operation,
  input  logic [itwp_pkg::NOW_W-1:0]    now,
  input  logic                          paused,
  input  logic                          tick,
  input  logic                          q_full,
  output logic                          q_push,
  output itwp_pkg::item_t               q_item
);
  import itwp_pkg::*;

  logic [CLS_W-1:0] cls;

  always_comb begin
    case (operation)
      OP_UPDATE: cls = CLS_UPDATE;
      OP_START:  cls = CLS_START;
      OP_STOP:   cls = CLS_STOP;
      OP_PAUSE:  cls = CLS_PAUSE;
      OP_RESUME: cls = CLS_RESUME;
      default:   cls = CLS_NONE;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cls    = cls;
    q_item.now    = NOW_W'(now[TIME_WIDTH-1:0]);
    q_item.paused = paused;
    q_item.tick   = tick;
  end

endmodule

/* rtl/core/itwp_queue.sv */
// Short FIFO between front and back end, built from flip-flops.
// Holds itwp_pkg::item_t entries. Uses itwp_pkg.
module itwp_queue #(
  parameter int DEPTH = itwp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  itwp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output itwp_pkg::item_t head
);
  import itwp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/itwp_back.sv */
// Back end: timer state, age update, interval compare and bit-serial remainder.
// Presents one result beat per item from its own registers. Uses itwp_pkg.
module itwp_back #(
  parameter int TIME_WIDTH = itwp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  itwp_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  itwp_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          fired,
  output logic                          running,
  output logic [itwp_pkg::AGE_W-1:0]    elapsed
);
  import itwp_pkg::*;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] S_IDLE = 2'd0;
  localparam logic [ST_W-1:0] S_CMP  = 2'd1;
  localparam logic [ST_W-1:0] S_DIV  = 2'd2;
  localparam logic [ST_W-1:0] S_OUT  = 2'd3;

  localparam int CNT_W = $clog2(AGE_W);

  logic [ST_W-1:0]       state;
  logic [AGE_W-1:0]      age;
  logic [TIME_WIDTH-1:0] last_time;
  logic                  active;
  logic                  fired_r;
  logic [INTERVAL_W:0]   rem;
  logic [CNT_W-1:0]      cnt;

  logic [TIME_WIDTH-1:0] now_tw;
  logic [TIME_WIDTH-1:0] delta;
  logic [AGE_W-1:0]      addend;
  logic [AGE_W:0]        sum_full;
  logic [AGE_W-1:0]      sum_sat;
  logic                  frozen;
  logic [INTERVAL_W:0]   rem_sh;
  logic [INTERVAL_W:0]   rem_next;

  assign now_tw   = q_item.now[TIME_WIDTH-1:0];
  assign delta    = now_tw - last_time;
  assign frozen   = q_item.paused && cfg.pausable;
  assign addend   = cfg.use_ticks ? AGE_W'(q_item.tick) : AGE_W'(delta);
  assign sum_full = {1'b0, age} + {1'b0, addend};
  assign sum_sat  = sum_full[AGE_W] ? '1 : sum_full[AGE_W-1:0];

  // One quotient bit per cycle: bring in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem[INTERVAL_W-1:0], age[AGE_W-1]};
  assign rem_next = (rem_sh >= {1'b0, cfg.interval}) ? rem_sh - {1'b0, cfg.interval} : rem_sh;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign fired     = fired_r;
  assign running   = active;
  assign elapsed   = age;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      age       <= '0;
      last_time <= '0;
      active    <= 1'b0;
      fired_r   <= 1'b0;
      rem       <= '0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            fired_r <= 1'b0;
            state   <= S_OUT;
            case (q_item.cls)
              CLS_UPDATE: begin
                if (active) begin
                  if (frozen) begin
                    last_time <= now_tw;
                  end else begin
                    age   <= sum_sat;
                    state <= S_CMP;
                    if (!cfg.use_ticks) begin
                      last_time <= now_tw;
                    end
                  end
                end
              end
              CLS_START: begin
                age <= '0;
                if (!cfg.use_ticks || !active) begin
                  last_time <= now_tw;
                end
                active <= 1'b1;
              end
              CLS_STOP: begin
                active <= 1'b0;
                age    <= '0;
              end
              CLS_PAUSE: begin
                active <= 1'b0;
              end
              CLS_RESUME: begin
                if (!active) begin
                  active    <= 1'b1;
                  last_time <= now_tw;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CMP: begin
          state <= S_OUT;
          if (age >= AGE_W'(cfg.interval)) begin
            fired_r <= 1'b1;
            if (cfg.single_shot) begin
              active <= 1'b0;
            end else if (cfg.interval != '0) begin
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Shift the dividend out of the age register; the remainder replaces it at the end.
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(AGE_W - 1)) begin
            age   <= AGE_W'(rem_next[INTERVAL_W-1:0]);
            state <= S_OUT;
          end else begin
            rem <= rem_next;
            age <= {age[AGE_W-2:0], 1'b0};
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
